@@ hw/rtl/assert_macros.svh @@
// -----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros for the checker file.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is low.
`define SFWS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// Clocked property that is also checked during reset.
`define SFWS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/sfws_pkg.sv @@
// -----------------------------------------------------------------------------
// sfws_pkg
// Types, command bytes and the action program table of the flash sequencer.
// -----------------------------------------------------------------------------
`default_nettype none

package sfws_pkg;

    localparam int PAGE_BYTES      = 256;
    localparam int SECTOR_BYTES    = 4096;   // power of two
    localparam int ADDRESS_BITS    = 24;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [23:0] ADDR_MASK   = 24'((64'd1 << ADDRESS_BITS) - 64'd1);
    localparam logic [23:0] SECTOR_MASK = 24'(SECTOR_BYTES - 1);

    localparam logic [7:0] CMD_READ    = 8'h03;
    localparam logic [7:0] CMD_PROGRAM = 8'h02;
    localparam logic [7:0] CMD_ERASE   = 8'h20;
    localparam logic [7:0] CMD_STATUS  = 8'h05;
    localparam logic [7:0] CMD_WREN    = 8'h06;
    localparam logic [7:0] CMD_WRDI    = 8'h04;

    typedef enum logic [2:0] {
        KIND_START  = 3'd0,
        KIND_DATA   = 3'd1,
        KIND_STATUS = 3'd2,
        KIND_OPEN   = 3'd3,
        KIND_CLOSE  = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        ACT_SEL_LOW  = 3'd0,
        ACT_SEND     = 3'd1,
        ACT_SEL_HIGH = 3'd2,
        ACT_STATUS   = 3'd3,
        ACT_DONE     = 3'd4,
        ACT_ERROR    = 3'd5
    } t_action;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_DATA = 2'd1,
        PH_POLL = 2'd2,
        PH_READ = 2'd3
    } t_phase;

    // What an accepted word turns into
    typedef enum logic [3:0] {
        CLS_START_EMPTY,
        CLS_START_ERASE,
        CLS_START_PROG,
        CLS_DATA,
        CLS_DATA_END,
        CLS_BUSY,
        CLS_POLL_PROG,
        CLS_POLL_ERASE,
        CLS_POLL_FINISH,
        CLS_OPEN,
        CLS_CLOSE,
        CLS_ERROR
    } t_cls;

    // Where a sent byte comes from
    typedef enum logic [2:0] {
        SRC_CONST,
        SRC_ADDR_HI,
        SRC_ADDR_MID,
        SRC_ADDR_LO,
        SRC_DATA
    } t_src;

    typedef logic [5:0] t_pc;

    typedef struct packed {
        t_action    action;
        t_src       src;
        logic [7:0] cbyte;
    } t_rom;

    // One queued command: a range of the program table plus its operands
    typedef struct packed {
        t_pc         first;
        t_pc         last;
        logic [23:0] addr;
        logic [7:0]  data_byte;
    } t_desc;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // Program table ranges
    localparam t_pc SCR_SH_ERASE  = 6'd0;   // select high, then erase
    localparam t_pc SCR_ERASE     = 6'd1;
    localparam t_pc SCR_POLL_END  = 6'd12;  // also the lone status request
    localparam t_pc SCR_SH_PROG   = 6'd13;
    localparam t_pc SCR_PROG      = 6'd14;
    localparam t_pc SCR_PROG_END  = 6'd21;
    localparam t_pc SCR_SH_FINISH = 6'd22;
    localparam t_pc SCR_FINISH    = 6'd23;
    localparam t_pc SCR_FIN_END   = 6'd26;
    localparam t_pc SCR_DATA      = 6'd27;
    localparam t_pc SCR_DATA_END  = 6'd31;
    localparam t_pc SCR_ERROR     = 6'd32;
    localparam t_pc SCR_OPEN      = 6'd33;
    localparam t_pc SCR_OPEN_END  = 6'd37;
    localparam t_pc SCR_CLOSE     = 6'd0;

    function automatic t_rom rom_entry(input t_pc idx);
        t_rom e;
        e = '{action: ACT_ERROR, src: SRC_CONST, cbyte: 8'h00};
        unique case (idx)
            6'd0, 6'd3, 6'd9, 6'd13, 6'd16, 6'd22, 6'd25, 6'd28:
                e.action = ACT_SEL_HIGH;
            6'd1, 6'd4, 6'd10, 6'd14, 6'd17, 6'd23, 6'd29, 6'd33:
                e.action = ACT_SEL_LOW;
            6'd2, 6'd15:
                e = '{action: ACT_SEND, src: SRC_CONST, cbyte: CMD_WREN};
            6'd5:
                e = '{action: ACT_SEND, src: SRC_CONST, cbyte: CMD_ERASE};
            6'd6, 6'd19, 6'd35:
                e = '{action: ACT_SEND, src: SRC_ADDR_HI, cbyte: 8'h00};
            6'd7, 6'd20, 6'd36:
                e = '{action: ACT_SEND, src: SRC_ADDR_MID, cbyte: 8'h00};
            6'd8, 6'd21, 6'd37:
                e = '{action: ACT_SEND, src: SRC_ADDR_LO, cbyte: 8'h00};
            6'd11, 6'd30:
                e = '{action: ACT_SEND, src: SRC_CONST, cbyte: CMD_STATUS};
            6'd12, 6'd31:
                e.action = ACT_STATUS;
            6'd18:
                e = '{action: ACT_SEND, src: SRC_CONST, cbyte: CMD_PROGRAM};
            6'd24:
                e = '{action: ACT_SEND, src: SRC_CONST, cbyte: CMD_WRDI};
            6'd26:
                e.action = ACT_DONE;
            6'd27:
                e = '{action: ACT_SEND, src: SRC_DATA, cbyte: 8'h00};
            6'd34:
                e = '{action: ACT_SEND, src: SRC_CONST, cbyte: CMD_READ};
            default:
                e.action = ACT_ERROR;
        endcase
        return e;
    endfunction

    function automatic logic sector_start(input logic [23:0] addr);
        return (addr & SECTOR_MASK) == 24'd0;
    endfunction

    function automatic logic [8:0] chunk_size(input logic [24:0] rem);
        return (rem < 25'(PAGE_BYTES)) ? rem[8:0] : 9'(PAGE_BYTES);
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/sfws_front.sv @@
// -----------------------------------------------------------------------------
// sfws_front
// Accepts request words, tracks the write/read phase and queues one command
// descriptor per word.
// -----------------------------------------------------------------------------
`default_nettype none

module sfws_front import sfws_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [2:0]  i_kind,
    input  wire logic [23:0] i_address,
    input  wire logic [24:0] i_length,
    input  wire logic [7:0]  i_data_byte,
    input  wire t_q_status   i_q_status,
    output logic             o_push,
    output t_desc            o_desc
);

    t_phase      r_phase, n_phase;
    logic [23:0] r_cur, n_cur;
    logic [24:0] r_rem, n_rem;
    logic [8:0]  r_chunk, n_chunk;
    logic        r_after, n_after;

    t_cls        cls;
    logic [23:0] addr_in;

    assign addr_in = i_address & ADDR_MASK;
    assign o_ready = !i_q_status.full;
    assign o_push  = i_valid && !i_q_status.full;

    always_comb begin
        priority if (i_kind == KIND_START && r_phase == PH_IDLE) begin
            if (i_length == 25'd0)
                cls = CLS_START_EMPTY;
            else if (sector_start(addr_in))
                cls = CLS_START_ERASE;
            else
                cls = CLS_START_PROG;
        end else if (i_kind == KIND_DATA && r_phase == PH_DATA && r_chunk != 9'd0) begin
            cls = (r_chunk == 9'd1) ? CLS_DATA_END : CLS_DATA;
        end else if (i_kind == KIND_STATUS && r_phase == PH_POLL) begin
            if (i_data_byte[0])
                cls = CLS_BUSY;
            else if (!r_after)
                cls = CLS_POLL_PROG;
            else if (r_rem == 25'd0)
                cls = CLS_POLL_FINISH;
            else if (sector_start(r_cur))
                cls = CLS_POLL_ERASE;
            else
                cls = CLS_POLL_PROG;
        end else if (i_kind == KIND_OPEN && r_phase == PH_IDLE) begin
            cls = CLS_OPEN;
        end else if (i_kind == KIND_CLOSE && r_phase == PH_READ) begin
            cls = CLS_CLOSE;
        end else begin
            cls = CLS_ERROR;
        end
    end

    // Next state
    always_comb begin
        n_phase = r_phase;
        n_cur   = r_cur;
        n_rem   = r_rem;
        n_chunk = r_chunk;
        n_after = r_after;
        unique case (cls)
            CLS_START_EMPTY: begin
                n_cur   = addr_in;
                n_rem   = i_length;
                n_phase = PH_IDLE;
            end
            CLS_START_ERASE: begin
                n_cur   = addr_in;
                n_rem   = i_length;
                n_after = 1'b0;
                n_phase = PH_POLL;
            end
            CLS_START_PROG: begin
                n_cur   = addr_in;
                n_rem   = i_length;
                n_chunk = chunk_size(i_length);
                n_phase = PH_DATA;
            end
            CLS_DATA: begin
                n_cur   = (r_cur + 24'd1) & ADDR_MASK;
                n_rem   = r_rem - 25'd1;
                n_chunk = r_chunk - 9'd1;
            end
            CLS_DATA_END: begin
                n_cur   = (r_cur + 24'd1) & ADDR_MASK;
                n_rem   = r_rem - 25'd1;
                n_chunk = r_chunk - 9'd1;
                n_after = 1'b1;
                n_phase = PH_POLL;
            end
            CLS_POLL_PROG: begin
                n_chunk = chunk_size(r_rem);
                n_phase = PH_DATA;
            end
            CLS_POLL_ERASE: begin
                n_after = 1'b0;
                n_phase = PH_POLL;
            end
            CLS_POLL_FINISH: n_phase = PH_IDLE;
            CLS_OPEN:        n_phase = PH_READ;
            CLS_CLOSE:       n_phase = PH_IDLE;
            CLS_BUSY, CLS_ERROR: begin
                n_phase = r_phase;
            end
            default: n_phase = r_phase;
        endcase
    end

    // Descriptor
    always_comb begin
        o_desc.addr      = r_cur;
        o_desc.data_byte = i_data_byte;
        o_desc.first     = SCR_ERROR;
        o_desc.last      = SCR_ERROR;
        unique case (cls)
            CLS_START_EMPTY: begin
                o_desc.first = SCR_FINISH;
                o_desc.last  = SCR_FIN_END;
            end
            CLS_START_ERASE: begin
                o_desc.addr  = addr_in;
                o_desc.first = SCR_ERASE;
                o_desc.last  = SCR_POLL_END;
            end
            CLS_START_PROG: begin
                o_desc.addr  = addr_in;
                o_desc.first = SCR_PROG;
                o_desc.last  = SCR_PROG_END;
            end
            CLS_DATA: begin
                o_desc.first = SCR_DATA;
                o_desc.last  = SCR_DATA;
            end
            CLS_DATA_END: begin
                o_desc.first = SCR_DATA;
                o_desc.last  = SCR_DATA_END;
            end
            CLS_BUSY: begin
                o_desc.first = SCR_POLL_END;
                o_desc.last  = SCR_POLL_END;
            end
            CLS_POLL_PROG: begin
                o_desc.first = SCR_SH_PROG;
                o_desc.last  = SCR_PROG_END;
            end
            CLS_POLL_ERASE: begin
                o_desc.first = SCR_SH_ERASE;
                o_desc.last  = SCR_POLL_END;
            end
            CLS_POLL_FINISH: begin
                o_desc.first = SCR_SH_FINISH;
                o_desc.last  = SCR_FIN_END;
            end
            CLS_OPEN: begin
                o_desc.addr  = addr_in;
                o_desc.first = SCR_OPEN;
                o_desc.last  = SCR_OPEN_END;
            end
            CLS_CLOSE: begin
                o_desc.first = SCR_CLOSE;
                o_desc.last  = SCR_CLOSE;
            end
            CLS_ERROR: begin
                o_desc.first = SCR_ERROR;
                o_desc.last  = SCR_ERROR;
            end
            default: begin
                o_desc.first = SCR_ERROR;
                o_desc.last  = SCR_ERROR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cur   <= 24'd0;
            r_rem   <= 25'd0;
            r_chunk <= 9'd0;
            r_after <= 1'b0;
        end else if (o_push) begin
            r_phase <= n_phase;
            r_cur   <= n_cur;
            r_rem   <= n_rem;
            r_chunk <= n_chunk;
            r_after <= n_after;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/sfws_queue.sv @@
// -----------------------------------------------------------------------------
// sfws_queue
// Small flop queue of command descriptors between front and back.
// -----------------------------------------------------------------------------
`default_nettype none

module sfws_queue import sfws_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF   // 2 or more
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_desc i_desc,
    input  wire logic  i_pop,
    output t_q_status  o_status,
    output t_desc      o_head
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_desc              r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr, r_rd;
    logic [CNT_W-1:0]   r_count;

    assign o_status.full  = r_count == CNT_W'(DEPTH);
    assign o_status.empty = r_count == '0;
    assign o_head         = r_mem[r_rd];

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push)
            r_mem[r_wr] <= i_desc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push)
                r_wr <= wrap_inc(r_wr);
            if (i_pop)
                r_rd <= wrap_inc(r_rd);
            if (i_push && !i_pop)
                r_count <= r_count + CNT_W'(1);
            else if (i_pop && !i_push)
                r_count <= r_count - CNT_W'(1);
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/sfws_back.sv @@
// -----------------------------------------------------------------------------
// sfws_back
// Walks the program table range of the head descriptor and drives one bus
// action per cycle into the output register whenever that register is free.
// -----------------------------------------------------------------------------
`default_nettype none

module sfws_back import sfws_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_q_status  i_q_status,
    input  wire t_desc      i_head,
    output logic            o_pop,
    output logic            o_valid,
    input  wire logic       i_ready,
    output t_action         o_action,
    output logic [7:0]      o_spi_byte,
    output logic            o_last
);

    logic       r_valid;
    logic       r_started;
    t_pc        r_pc;
    t_action    r_action;
    logic [7:0] r_byte;
    logic       r_last;

    t_pc        n_pc;
    t_rom       ent;
    logic [7:0] n_byte;
    logic       out_free;
    logic       emit;
    logic       at_end;

    always_comb begin
        n_pc     = r_started ? r_pc : i_head.first;
        ent      = rom_entry(n_pc);
        out_free = !r_valid || i_ready;
        emit     = !i_q_status.empty && out_free;
        at_end   = n_pc == i_head.last;
        o_pop    = emit && at_end;
        unique case (ent.src)
            SRC_CONST:    n_byte = ent.cbyte;
            SRC_ADDR_HI:  n_byte = i_head.addr[23:16];
            SRC_ADDR_MID: n_byte = i_head.addr[15:8];
            SRC_ADDR_LO:  n_byte = i_head.addr[7:0];
            SRC_DATA:     n_byte = i_head.data_byte;
            default:      n_byte = 8'h00;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_started <= 1'b0;
        end else if (emit) begin
            r_valid   <= 1'b1;
            r_started <= !at_end;
        end else if (i_ready) begin
            r_valid   <= 1'b0;
        end
    end

    // Payload: advance only on a word taken into the output register
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_pc     <= n_pc + t_pc'(1);
            r_action <= ent.action;
            r_byte   <= n_byte;
            r_last   <= at_end;
        end
    end

    assign o_valid    = r_valid;
    assign o_action   = r_action;
    assign o_spi_byte = r_byte;
    assign o_last     = r_last;

endmodule

`default_nettype wire

@@ hw/rtl/spi_flash_write_sequencer.sv @@
// -----------------------------------------------------------------------------
// spi_flash_write_sequencer
// Turns flash write and read requests into a stream of SPI bus actions.
// -----------------------------------------------------------------------------
// Input stream: tuser carries the request kind (start write, data byte, status
// byte, open read, close read); tdata carries address, length and data byte.
// Output stream: one word per bus action (select low, send byte, select high,
// request status, write done, error); tlast marks the final action caused by
// one input word.
// The front stage takes one input word per cycle whenever the descriptor
// queue has room, updates the phase and pushes one descriptor. The back stage
// emits one action per cycle from a constant action table while the output
// is not stalled, so an input word yields as many output words as it has
// actions (1 for a data byte, up to 13 when the status word closing a program
// poll starts a sector erase). The first action passes through the queue and
// the output register before it appears on the output. Queue depth sets how many
// multi-action preambles can be absorbed while the receiver stalls.
// A stalled output holds its word; the back stage and then the front stage
// stop once the queue fills. Reset (synchronous, active low) empties the
// queue, drops the output word and returns to idle.
// -----------------------------------------------------------------------------
`default_nettype none

module spi_flash_write_sequencer import sfws_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // [23:0] address, [48:24] length, [56:49] data_byte, [63:57] zero
    input  wire logic [63:0] i_s_axis_tdata,
    // [2:0] kind
    input  wire logic [2:0]  i_s_axis_tuser,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // [2:0] action, [10:3] spi_byte, [15:11] zero
    output logic [15:0]      o_m_axis_tdata,
    output logic             o_m_axis_tlast
);

    t_q_status  q_status;
    t_desc      push_desc;
    t_desc      head_desc;
    logic       push;
    logic       pop;
    t_action    action;
    logic [7:0] spi_byte;

    sfws_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_kind      (i_s_axis_tuser),
        .i_address   (i_s_axis_tdata[23:0]),
        .i_length    (i_s_axis_tdata[48:24]),
        .i_data_byte (i_s_axis_tdata[56:49]),
        .i_q_status  (q_status),
        .o_push      (push),
        .o_desc      (push_desc)
    );

    sfws_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_desc   (push_desc),
        .i_pop    (pop),
        .o_status (q_status),
        .o_head   (head_desc)
    );

    sfws_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (q_status),
        .i_head     (head_desc),
        .o_pop      (pop),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_action   (action),
        .o_spi_byte (spi_byte),
        .o_last     (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {5'b0, spi_byte, action};

endmodule

`default_nettype wire

@@ hw/rtl/sfws_checker.sv @@
// -----------------------------------------------------------------------------
// sfws_checker
// Port-level checks of the flash sequencer output stream.
// -----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sfws_checker import sfws_pkg::*; (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [15:0] i_m_axis_tdata,
    input wire logic        i_m_axis_tlast
);

    `SFWS_ASSERT_ALWAYS(a_reset_drops_word, i_clk, !i_rst_n |=> !i_m_axis_tvalid, "output valid after reset")

    `SFWS_ASSERT(a_stall_holds, i_clk, i_rst_n, i_m_axis_tvalid && !i_m_axis_tready |=> i_m_axis_tvalid && $stable(i_m_axis_tdata) && $stable(i_m_axis_tlast), "stalled word changed")

    `SFWS_ASSERT(a_byte_only_on_send, i_clk, i_rst_n, i_m_axis_tvalid && i_m_axis_tdata[2:0] != ACT_SEND |-> i_m_axis_tdata[10:3] == 8'h00, "byte set on non-send action")

    `SFWS_ASSERT(a_error_is_last, i_clk, i_rst_n, i_m_axis_tvalid && i_m_axis_tdata[2:0] == ACT_ERROR |-> i_m_axis_tlast, "error action not last")

    `SFWS_ASSERT(a_done_is_last, i_clk, i_rst_n, i_m_axis_tvalid && i_m_axis_tdata[2:0] == ACT_DONE |-> i_m_axis_tlast, "done action not last")

endmodule

bind spi_flash_write_sequencer sfws_checker u_sfws_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .i_m_axis_tdata  (o_m_axis_tdata),
    .i_m_axis_tlast  (o_m_axis_tlast)
);

`default_nettype wire

@@ verif/spi_flash_write_sequencer_tb.sv @@
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// spi_flash_write_sequencer_tb
// Self-checking stream testbench for the SPI flash write sequencer.
// -----------------------------------------------------------------------------
// A queue of request words (start write, data, status, open/close read and
// out-of-place words) is built up front: a short directed set, then random
// well-formed write and read sequences with noise mixed in. A clocked driver
// sends them in bursts with random gaps; a clocked monitor takes bus actions
// under its own stall pattern and checks each one against the actions that
// an in-bench flash sequencer model predicts from every accepted word.
// -----------------------------------------------------------------------------

module spi_flash_write_sequencer_tb;
    import sfws_pkg::*;

    localparam int PLANNED_WORDS   = 410;
    localparam int WATCHDOG_CYCLES = 2000;
    localparam int TAIL_CYCLES     = 16;

    typedef struct packed {
        logic [2:0]  kind;
        logic [23:0] addr;
        logic [24:0] len;
        logic [7:0]  data_val;
        logic        drain;
    } flash_word_t;

    typedef struct packed {
        t_action    act;
        logic [7:0] spi;
        logic       last;
    } bus_action_t;

    logic        i_clk;
    logic        rst_n   = 1'b0;
    logic        s_valid = 1'b0;
    logic [63:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_ready = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic [15:0] m_tdata;
    logic        m_tlast;

    spi_flash_write_sequencer dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        // [23:0] address, [48:24] length, [56:49] data_byte, [63:57] zero
        .i_s_axis_tdata  (s_tdata),
        // [2:0] kind
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        // [2:0] action, [10:3] spi_byte, [15:11] zero
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    flash_word_t words_to_send[$];
    bus_action_t bus_actions_due[$];
    bus_action_t step_acts[$];

    int actions_predicted = 0;
    int actions_seen      = 0;
    int words_taken       = 0;
    int writes_done       = 0;
    int mismatches        = 0;
    int noise_pct         = 0;

    // Model state of the sequencer
    t_phase      fl_phase      = PH_IDLE;
    logic [23:0] fl_addr       = '0;
    logic [24:0] fl_left       = '0;
    logic [8:0]  fl_chunk      = '0;
    logic        fl_after_prog = 1'b0;

    // ---------------------------------------------------------------- model
    task automatic put_act(input t_action a, input logic [7:0] b);
        step_acts.push_back('{act: a, spi: b, last: 1'b0});
    endtask

    task automatic cmd_one(input logic [7:0] cmd);
        put_act(ACT_SEL_LOW, 8'h00);
        put_act(ACT_SEND, cmd);
        put_act(ACT_SEL_HIGH, 8'h00);
    endtask

    task automatic cmd_addr(input logic [7:0] cmd, input logic [23:0] a);
        put_act(ACT_SEL_LOW, 8'h00);
        put_act(ACT_SEND, cmd);
        put_act(ACT_SEND, a[23:16]);
        put_act(ACT_SEND, a[15:8]);
        put_act(ACT_SEND, a[7:0]);
    endtask

    task automatic begin_poll(input logic after_prog);
        put_act(ACT_SEL_LOW, 8'h00);
        put_act(ACT_SEND, CMD_STATUS);
        put_act(ACT_STATUS, 8'h00);
        fl_after_prog = after_prog;
        fl_phase = PH_POLL;
    endtask

    task automatic begin_program();
        cmd_one(CMD_WREN);
        cmd_addr(CMD_PROGRAM, fl_addr);
        fl_chunk = (fl_left < 25'(PAGE_BYTES)) ? fl_left[8:0] : 9'(PAGE_BYTES);
        fl_phase = PH_DATA;
    endtask

    task automatic begin_chunk();
        if ((fl_addr & SECTOR_MASK) == 24'd0) begin
            cmd_one(CMD_WREN);
            cmd_addr(CMD_ERASE, fl_addr);
            put_act(ACT_SEL_HIGH, 8'h00);
            begin_poll(1'b0);
        end else begin
            begin_program();
        end
    endtask

    task automatic end_write();
        cmd_one(CMD_WRDI);
        put_act(ACT_DONE, 8'h00);
        fl_phase = PH_IDLE;
    endtask

    task automatic predict_bus_actions(input flash_word_t w);
        step_acts.delete();
        if (w.kind == KIND_START && fl_phase == PH_IDLE) begin
            fl_addr = w.addr;
            fl_left = w.len;
            if (w.len == 25'd0) end_write();
            else begin_chunk();
        end else if (w.kind == KIND_DATA && fl_phase == PH_DATA && fl_chunk != 9'd0) begin
            put_act(ACT_SEND, w.data_val);
            fl_addr  = fl_addr + 24'd1;
            fl_left  = fl_left - 25'd1;
            fl_chunk = fl_chunk - 9'd1;
            if (fl_chunk == 9'd0) begin
                put_act(ACT_SEL_HIGH, 8'h00);
                begin_poll(1'b1);
            end
        end else if (w.kind == KIND_STATUS && fl_phase == PH_POLL) begin
            if (w.data_val[0]) begin
                put_act(ACT_STATUS, 8'h00);
            end else begin
                put_act(ACT_SEL_HIGH, 8'h00);
                if (!fl_after_prog) begin_program();
                else if (fl_left != 25'd0) begin_chunk();
                else end_write();
            end
        end else if (w.kind == KIND_OPEN && fl_phase == PH_IDLE) begin
            cmd_addr(CMD_READ, w.addr);
            fl_phase = PH_READ;
        end else if (w.kind == KIND_CLOSE && fl_phase == PH_READ) begin
            put_act(ACT_SEL_HIGH, 8'h00);
            fl_phase = PH_IDLE;
        end else begin
            put_act(ACT_ERROR, 8'h00);
        end
        step_acts[step_acts.size() - 1].last = 1'b1;
        foreach (step_acts[i]) bus_actions_due.push_back(step_acts[i]);
        actions_predicted += step_acts.size();
    endtask

    // ------------------------------------------------------------- stimulus
    task automatic add_word(input logic [2:0] k, input logic [23:0] a, input logic [24:0] l,
                            input logic [7:0] d, input logic drain = 1'b0);
        words_to_send.push_back('{kind: k, addr: a, len: l, data_val: d, drain: drain});
    endtask

    function automatic bit kind_fits(input logic [2:0] k, input t_phase ctx);
        case (ctx)
            PH_IDLE: return k == KIND_START || k == KIND_OPEN;
            PH_DATA: return k == KIND_DATA;
            PH_POLL: return k == KIND_STATUS;
            default: return k == KIND_CLOSE;
        endcase
    endfunction

    // Word that is out of place in the given phase, all fields random
    task automatic add_noise(input t_phase ctx);
        logic [2:0] k;
        do begin
            k = 3'($urandom_range(0, 7));
        end while (kind_fits(k, ctx));
        add_word(k, 24'($urandom), 25'($urandom), 8'($urandom));
    endtask

    task automatic maybe_noise(input t_phase ctx);
        if ($urandom_range(0, 99) < noise_pct) add_noise(ctx);
    endtask

    task automatic plan_poll();
        repeat ($urandom_range(0, 2)) begin
            maybe_noise(PH_POLL);
            add_word(KIND_STATUS, 24'($urandom), 25'($urandom), 8'($urandom) | 8'h01);
        end
        maybe_noise(PH_POLL);
        add_word(KIND_STATUS, 24'($urandom), 25'($urandom), 8'($urandom) & 8'hFE);
    endtask

    task automatic plan_write(input logic [23:0] a, input logic [24:0] l,
                              input logic drain);
        logic [23:0] cur;
        logic [24:0] rem;
        int          chunk;
        cur = a;
        rem = l;
        add_word(KIND_START, a, l, 8'($urandom), drain);
        while (rem != 25'd0) begin
            if ((cur & SECTOR_MASK) == 24'd0) plan_poll();
            chunk = (rem < 25'(PAGE_BYTES)) ? int'(rem) : PAGE_BYTES;
            repeat (chunk) begin
                maybe_noise(PH_DATA);
                add_word(KIND_DATA, 24'($urandom), 25'($urandom), 8'($urandom));
            end
            rem = rem - 25'(chunk);
            cur = cur + 24'(chunk);
            plan_poll();
        end
    endtask

    task automatic plan_directed();
        add_word(KIND_START, 24'hFFFFFF, 25'd0, 8'hFF);       // zero-length write
        add_word(KIND_OPEN, 24'hABCDEF, 25'd0, 8'h00);
        add_word(KIND_OPEN, 24'h000000, 25'h1FFFFFF, 8'h00);  // second open, error
        add_word(KIND_CLOSE, 24'h000000, 25'd0, 8'h00);
        add_word(KIND_CLOSE, 24'h000000, 25'd0, 8'h00);       // close when idle
        add_word(3'd7, 24'hFFFFFF, 25'h1FFFFFF, 8'hFF);
        add_word(KIND_STATUS, 24'h000000, 25'd0, 8'h00);      // status when idle
        add_word(KIND_START, 24'h001000, 25'd1, 8'h00);       // sector start, erase
        add_word(KIND_DATA, 24'h000000, 25'd0, 8'h55);        // data while polling
        add_word(KIND_STATUS, 24'h000000, 25'd0, 8'hFF);      // busy
        add_word(KIND_STATUS, 24'h000000, 25'd0, 8'h00);
        add_word(KIND_STATUS, 24'h000000, 25'd0, 8'h00);      // status while taking data
        add_word(KIND_START, 24'h000000, 25'd5, 8'h00);       // start while taking data
        add_word(KIND_DATA, 24'h000000, 25'd0, 8'hFF);
        add_word(KIND_STATUS, 24'h000000, 25'd0, 8'h01);
        add_word(KIND_STATUS, 24'h000000, 25'd0, 8'hFE);
        add_word(KIND_START, 24'h000FFF, 25'd2, 8'h00);       // crosses a sector, no erase
        add_word(KIND_DATA, 24'h000000, 25'd0, 8'h00);
        add_word(KIND_DATA, 24'h000000, 25'd0, 8'hA5);
        add_word(KIND_STATUS, 24'h000000, 25'd0, 8'h00);
        add_word(3'd5, 24'h000000, 25'd0, 8'h00);
        add_word(3'd6, 24'h000000, 25'd0, 8'h00);
    endtask

    task automatic plan_random();
        bit          big_done;
        logic [23:0] a;
        int          pick;
        big_done = 1'b0;
        while (words_to_send.size() < PLANNED_WORDS) begin
            noise_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 15);
            pick = $urandom_range(0, 99);
            if (!big_done && words_to_send.size() > 120) begin
                // A full page, address wrap and an erase at the second chunk
                noise_pct = 1;
                plan_write(24'hFFFF00, 25'd258, 1'b1);
                big_done = 1'b1;
            end else if (pick < 60) begin
                case ($urandom_range(0, 2))
                    0: a = {12'($urandom), 12'h000};
                    1: a = 24'($urandom);
                    default: a = {12'($urandom), 12'hFFF - 12'($urandom_range(0, 3))};
                endcase
                plan_write(a, ($urandom_range(0, 9) == 0) ? 25'd0 : 25'($urandom_range(1, 12)),
                           $urandom_range(0, 9) == 0);
            end else if (pick < 82) begin
                add_word(KIND_OPEN, 24'($urandom), 25'($urandom), 8'($urandom),
                         $urandom_range(0, 9) == 0);
                repeat ($urandom_range(0, 2)) add_noise(PH_READ);
                add_word(KIND_CLOSE, 24'($urandom), 25'($urandom), 8'($urandom));
            end else begin
                add_noise(PH_IDLE);
            end
        end
    endtask

    // --------------------------------------------------------------- driver
    flash_word_t on_bus     = '0;
    int          burst_left = 1;
    int          gap_left   = 0;

    always @(posedge i_clk) begin
        flash_word_t nxt;
        if (!rst_n) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_bus_actions(on_bus);
                words_taken <= words_taken + 1;
            end
            if (!s_valid || s_ready) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    s_valid  <= 1'b0;
                end else if (words_to_send.size() == 0 ||
                             (words_to_send[0].drain && actions_predicted != actions_seen)) begin
                    // hold until every pending action has come out
                    s_valid <= 1'b0;
                end else begin
                    nxt = words_to_send.pop_front();
                    on_bus  <= nxt;
                    s_tdata <= {7'd0, nxt.data_val, nxt.len, nxt.addr};
                    s_tuser <= nxt.kind;
                    s_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 30);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------- receiver
    int       stall_mode = 0;
    int       mode_left  = 0;
    bit [1:0] stall_tick = '0;

    always @(posedge i_clk) begin
        if (!rst_n) begin
            m_ready <= 1'b0;
        end else begin
            stall_tick <= stall_tick + 2'd1;
            if (mode_left == 0) begin
                stall_mode <= $urandom_range(0, 3);
                mode_left  <= $urandom_range(20, 120);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (stall_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= $urandom_range(0, 3) != 0;
                2: m_ready <= $urandom_range(0, 9) < 3;
                default: m_ready <= stall_tick == 2'd0;
            endcase
        end
    end

    // -------------------------------------------------------------- monitor
    task automatic report_mismatch(input string what, input int want, input int got);
        $display("[%0t] mismatch on %s: expected %0h, got %0h", $time, what, want, got);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        bus_action_t due;
        if (rst_n && m_valid && m_ready) begin
            actions_seen <= actions_seen + 1;
            if (m_tdata[2:0] == ACT_DONE) writes_done <= writes_done + 1;
            if (bus_actions_due.size() == 0) begin
                report_mismatch("action with none pending", 0, m_tdata[2:0]);
            end else begin
                due = bus_actions_due.pop_front();
                if (m_tdata[2:0] != due.act) report_mismatch("action", due.act, m_tdata[2:0]);
                if (m_tdata[10:3] != due.spi) report_mismatch("spi_byte", due.spi, m_tdata[10:3]);
                if (m_tlast != due.last) report_mismatch("tlast", due.last, m_tlast);
            end
        end
    end

    // ------------------------------------------------------------- watchdog
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (!rst_n || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_CYCLES) begin
                $display("[%0t] no word moved for %0d cycles", $time, WATCHDOG_CYCLES);
                $display("FAILURE");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------ main flow
    initial begin
        plan_directed();
        plan_random();
        repeat (5) @(posedge i_clk);
        rst_n <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (words_to_send.size() != 0 || s_valid || actions_predicted != actions_seen);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Sent %0d request words; checked %0d bus actions, %0d writes finished.",
                 words_taken, actions_seen, writes_done);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("FAILURE");
        end
        $finish;
    end

endmodule
